/* rtl/core/m4m_pkg.sv */
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// Holds the request/result payload structs and the controller command struct.
// No dependencies.
`default_nettype none

package m4m_pkg;

    // Matrix geometry
    localparam int MAT_DIM = 4;
    localparam int CELLS   = MAT_DIM * MAT_DIM;
    localparam int IDX_W   = $clog2(MAT_DIM);
    localparam int CELL_W  = $clog2(CELLS);

    // Element format: port fields are always 32 bits, Q16.16
    localparam int FIELD_W    = 32;
    localparam int ELEM_W_DEF = 32;
    localparam int FRAC_W     = 16;

    // Input request: one element of each operand
    typedef struct packed {
        logic signed [FIELD_W-1:0] a_element;
        logic signed [FIELD_W-1:0] b_element;
    } t_m4m_req;

    // Output response: one product element
    typedef struct packed {
        logic signed [FIELD_W-1:0] product_value;
        logic [IDX_W-1:0]          product_column;
        logic [IDX_W-1:0]          product_row;
        logic                      final_flag;
    } t_m4m_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic              wr_en;
        logic [CELL_W-1:0] wr_addr;
        logic              rd_valid;
        logic [CELL_W-1:0] rd_a_addr;
        logic [CELL_W-1:0] rd_b_addr;
        logic              first;
        logic              last;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  row;
        logic              fin;
    } t_m4m_cmd;

endpackage

`default_nettype wire

/* rtl/core/matrix4_multiply.sv */
// The sixteen requests of a matrix pair are loaded first; the single
// multiply-accumulate unit then computes the sixteen products, column by column,
// while the output is not stalled. Requests stall until the last product is issued.
// Reset: synchronous active-low; clears counters, state and valid bits only.
// Top level of the 4x4 Q16.16 matrix multiplier; uses m4m_pkg, m4m_ctrl, m4m_datapath.
`default_nettype none

module matrix4_multiply
    import m4m_pkg::*;
#(
    parameter int ELEMENT_WIDTH = ELEM_W_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    output logic          o_req_stall,
    input  wire t_m4m_req i_req,
    output logic          o_rsp_valid,
    input  wire logic     i_rsp_stall,
    output t_m4m_rsp      o_rsp
);

    t_m4m_cmd cmd;
    logic     adv;

    m4m_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_adv       (adv),
        .o_cmd       (cmd)
    );

    m4m_datapath #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .o_adv       (adv),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

/* rtl/core/m4m_ctrl.sv */
// Controller: load counter and multiply-accumulate sequencer.
// Depends on m4m_pkg; drives t_m4m_cmd to m4m_datapath.
`default_nettype none

module m4m_ctrl
    import m4m_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    output logic          o_req_stall,
    input  wire logic     i_adv,
    output t_m4m_cmd      o_cmd
);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_CALC = 1'b1;

    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAT_DIM - 1);

    logic              r_state, n_state;
    logic [CELL_W-1:0] r_load_pos, n_load_pos;
    logic [IDX_W-1:0]  r_col, n_col;
    logic [IDX_W-1:0]  r_row, n_row;
    logic [IDX_W-1:0]  r_k, n_k;

    logic accept;
    logic issue;
    logic k_end, r_end, c_end;

    assign o_req_stall = (r_state != ST_LOAD);
    assign accept      = i_req_valid && (r_state == ST_LOAD);
    assign issue       = (r_state == ST_CALC) && i_adv;

    assign k_end = (r_k == LAST_IDX);
    assign r_end = (r_row == LAST_IDX);
    assign c_end = (r_col == LAST_IDX);

    // Next-state and counter logic
    always_comb begin
        n_state    = r_state;
        n_load_pos = r_load_pos;
        n_col      = r_col;
        n_row      = r_row;
        n_k        = r_k;
        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (r_load_pos == LAST_CELL) begin
                        n_load_pos = '0;
                        n_state    = ST_CALC;
                    end else begin
                        n_load_pos = r_load_pos + 1'b1;
                    end
                end
            end
            ST_CALC: begin
                if (issue) begin
                    if (k_end) begin
                        n_k = '0;
                        if (r_end) begin
                            n_row = '0;
                            if (c_end) begin
                                n_col   = '0;
                                n_state = ST_LOAD;
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_pos <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_load_pos <= n_load_pos;
            r_col      <= n_col;
            r_row      <= n_row;
            r_k        <= n_k;
        end
    end

    // Commands: A[k][r] sits at k*D+r, B[c][k] at c*D+k
    always_comb begin
        o_cmd.wr_en     = accept;
        o_cmd.wr_addr   = r_load_pos;
        o_cmd.rd_valid  = issue;
        o_cmd.rd_a_addr = CELL_W'(r_k * MAT_DIM) + CELL_W'(r_row);
        o_cmd.rd_b_addr = CELL_W'(r_col * MAT_DIM) + CELL_W'(r_k);
        o_cmd.first     = (r_k == '0);
        o_cmd.last      = k_end;
        o_cmd.col       = r_col;
        o_cmd.row       = r_row;
        o_cmd.fin       = k_end && r_end && c_end;
    end

endmodule

`default_nettype wire

/* rtl/core/m4m_datapath.sv */
// Datapath: operand stores, one multiply-accumulate pipeline, floor shift,
// saturation and the result register. Depends on m4m_pkg; driven by m4m_ctrl.
`default_nettype none

module m4m_datapath
    import m4m_pkg::*;
#(
    parameter int ELEMENT_WIDTH = ELEM_W_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_m4m_cmd i_cmd,
    input  wire t_m4m_req i_req,
    output logic          o_adv,
    output logic          o_rsp_valid,
    input  wire logic     i_rsp_stall,
    output t_m4m_rsp      o_rsp
);

    localparam int EW    = ELEMENT_WIDTH;
    localparam int PW    = 2 * EW;
    localparam int ACC_W = PW + $clog2(MAT_DIM);

    // Operand stores
    logic [EW-1:0] r_left_store  [CELLS];
    logic [EW-1:0] r_right_store [CELLS];

    // Stage 1: read data
    logic signed [EW-1:0] r_rd_a, r_rd_b;
    logic                 r_v1, r_first1, r_last1, r_fin1;
    logic [IDX_W-1:0]     r_col1, r_row1;

    // Stage 2: product
    logic signed [PW-1:0] r_prod;
    logic                 r_v2, r_first2, r_last2, r_fin2;
    logic [IDX_W-1:0]     r_col2, r_row2;

    // Stage 3: accumulator
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_done3, r_fin3;
    logic [IDX_W-1:0]        r_col3, r_row3;

    // Result register
    logic     r_rsp_valid;
    t_m4m_rsp r_rsp;

    logic signed [ACC_W-1:0] shifted;
    logic [ACC_W-EW:0]       top_bits;
    logic signed [EW-1:0]    sat_val;

    // Whole pipeline moves unless a finished result is held by stall
    assign o_adv = !r_rsp_valid || !i_rsp_stall;

    // Store writes during loading
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_left_store[i_cmd.wr_addr]  <= i_req.a_element[EW-1:0];
            r_right_store[i_cmd.wr_addr] <= i_req.b_element[EW-1:0];
        end
    end

    // Registered store reads
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_rd_a   <= r_left_store[i_cmd.rd_a_addr];
            r_rd_b   <= r_right_store[i_cmd.rd_b_addr];
            r_first1 <= i_cmd.first;
            r_last1  <= i_cmd.last;
            r_fin1   <= i_cmd.fin;
            r_col1   <= i_cmd.col;
            r_row1   <= i_cmd.row;
        end
    end

    // Multiply
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_prod   <= r_rd_a * r_rd_b;
            r_first2 <= r_first1;
            r_last2  <= r_last1;
            r_fin2   <= r_fin1;
            r_col2   <= r_col1;
            r_row2   <= r_row1;
        end
    end

    // Accumulate exact sum of products
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            if (r_v2) begin
                r_acc <= (r_first2 ? ACC_W'(0) : r_acc) + ACC_W'(r_prod);
            end
            r_fin3 <= r_fin2;
            r_col3 <= r_col2;
            r_row3 <= r_row2;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_done3     <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else if (o_adv) begin
            r_v1        <= i_cmd.rd_valid;
            r_v2        <= r_v1;
            r_done3     <= r_v2 && r_last2;
            r_rsp_valid <= r_done3;
        end
    end

    // Floor shift and saturate to the element width
    always_comb begin
        shifted  = r_acc >>> FRAC_W;
        top_bits = shifted[ACC_W-1:EW-1];
        if ((&top_bits) || !(|top_bits)) begin
            sat_val = shifted[EW-1:0];
        end else if (shifted[ACC_W-1]) begin
            sat_val = {1'b1, {(EW-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(EW-1){1'b1}}};
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (o_adv && r_done3) begin
            r_rsp.product_value  <= FIELD_W'(sat_val);
            r_rsp.product_column <= r_col3;
            r_rsp.product_row    <= r_row3;
            r_rsp.final_flag     <= r_fin3;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

/* sim/matrix4_multiply_tb.sv */
// Self-checking testbench for matrix4_multiply: streams 4x4 Q16.16 matrix pairs
// and compares every product element with an in-bench fixed-point predictor.
// Depends on m4m_pkg (payload structs, geometry) and the matrix4_multiply RTL.
`timescale 1ns / 1ps

module matrix4_multiply_tb;
    import m4m_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [31:0] E_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] E_MIN = 32'sh8000_0000;

    localparam logic signed [67:0] SUM_MAX = 68'sd2147483647;
    localparam logic signed [67:0] SUM_MIN = -SUM_MAX - 68'sd1;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_req_valid;
    logic     o_req_stall;
    t_m4m_req i_req;
    logic     o_rsp_valid;
    logic     i_rsp_stall;
    t_m4m_rsp o_rsp;

    matrix4_multiply dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor state: operand stores and load position
    logic signed [31:0] left_cells  [CELLS];
    logic signed [31:0] right_cells [CELLS];
    int                 fill_count;
    t_m4m_rsp           pending_products[$];

    int  error_count;
    int  cycle_count;
    bit  idle_on;
    int  sender_gap_pct;
    int  stall_left;
    int  quiet_left;

    // One product element: exact dot product, floor shift, saturate
    function automatic logic signed [31:0] dot_q16(input int col, input int row);
        logic signed [67:0] acc;
        longint             prod;
        acc = '0;
        for (int k = 0; k < MAT_DIM; k++) begin
            prod = longint'(left_cells[k*MAT_DIM + row]) *
                   longint'(right_cells[col*MAT_DIM + k]);
            acc  = acc + prod;
        end
        acc = acc >>> FRAC_W;
        if (acc > SUM_MAX) acc = SUM_MAX;
        if (acc < SUM_MIN) acc = SUM_MIN;
        return acc[31:0];
    endfunction

    // Store one accepted pair; after the last pair queue all sixteen products
    task automatic load_pair(input logic signed [31:0] a, input logic signed [31:0] b);
        t_m4m_rsp exp_rsp;
        left_cells[fill_count]  = a;
        right_cells[fill_count] = b;
        fill_count++;
        if (fill_count == CELLS) begin
            fill_count = 0;
            for (int c = 0; c < MAT_DIM; c++) begin
                for (int r = 0; r < MAT_DIM; r++) begin
                    exp_rsp.product_value  = dot_q16(c, r);
                    exp_rsp.product_column = IDX_W'(c);
                    exp_rsp.product_row    = IDX_W'(r);
                    exp_rsp.final_flag     = (c == MAT_DIM-1) && (r == MAT_DIM-1);
                    pending_products.push_back(exp_rsp);
                end
            end
        end
    endtask

    // Drive one request and hold it until accepted; valid stays high after unless a random sender gap drops it
    task automatic send_pair(input logic signed [31:0] a, input logic signed [31:0] b);
        i_req_valid <= 1'b1;
        i_req       <= '{a_element: a, b_element: b};
        do @(posedge i_clk); while (o_req_stall);
        load_pair(a, b);
        if (idle_on && $urandom_range(0, 99) < sender_gap_pct) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic send_matrices(input logic signed [31:0] lhs [CELLS],
                                 input logic signed [31:0] rhs [CELLS]);
        for (int i = 0; i < CELLS; i++) send_pair(lhs[i], rhs[i]);
    endtask

    // Half moderate values so sums stay in range; the rest full-range values and corners
    function automatic logic signed [31:0] rand_element();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return $signed($urandom_range(0, 1 << 20)) - 32'sd524288;
        if (pick < 8) return $signed($urandom);
        case ($urandom_range(0, 6))
            0: return E_MAX;
            1: return E_MIN;
            2: return '0;
            3: return -32'sd1;
            4: return 32'sd1;
            5: return Q_ONE;
            default: return -Q_ONE;
        endcase
    endfunction

    // Identity on the left passes the right operand through unchanged
    task automatic test_identity_passthrough();
        logic signed [31:0] lhs [CELLS];
        logic signed [31:0] rhs [CELLS];
        logic signed [31:0] corners [8];
        corners = '{E_MAX, E_MIN, 32'sd0, -32'sd1, 32'sd1, Q_ONE, -Q_ONE, 32'sh5555_AAAA};
        for (int i = 0; i < CELLS; i++) begin
            lhs[i] = ((i / MAT_DIM) == (i % MAT_DIM)) ? Q_ONE : '0;
            rhs[i] = (i < 8) ? corners[i] : rand_element();
        end
        send_matrices(lhs, rhs);
    endtask

    // Rows of A and columns of B at opposite extremes: both saturation bounds
    task automatic test_saturation();
        logic signed [31:0] lhs [CELLS];
        logic signed [31:0] rhs [CELLS];
        for (int i = 0; i < CELLS; i++) begin
            lhs[i] = ((i % MAT_DIM) % 2 == 1) ? E_MIN : E_MAX;
            rhs[i] = ((i / MAT_DIM) % 2 == 1) ? E_MIN : E_MAX;
        end
        send_matrices(lhs, rhs);
    endtask

    // Random matrix pairs; while idling is on, the sender idles in some runs and the receiver stalls
    task automatic test_random_matrices(input int runs);
        logic signed [31:0] lhs [CELLS];
        logic signed [31:0] rhs [CELLS];
        for (int n = 0; n < runs; n++) begin
            sender_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
            for (int i = 0; i < CELLS; i++) begin
                lhs[i] = rand_element();
                rhs[i] = rand_element();
            end
            send_matrices(lhs, rhs);
        end
    endtask

    // Closing stretch: no idling anywhere, runs follow back to back
    task automatic test_back_to_back(input int runs);
        idle_on = 1'b0;
        test_random_matrices(runs);
    endtask

    // Receiver stall bursts, with quiet stretches between them
    always @(posedge i_clk) begin
        if (!idle_on || !i_rst_n) begin
            i_rsp_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_rsp_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (quiet_left > 0) begin
            i_rsp_stall <= 1'b0;
            quiet_left  <= quiet_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_rsp_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 17);
            quiet_left  <= $urandom_range(0, 40);
        end else begin
            i_rsp_stall <= 1'b0;
        end
    end

    // Compare each accepted product with the oldest expectation
    always @(posedge i_clk) begin
        t_m4m_rsp exp_rsp;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (pending_products.size() == 0) begin
                $error("unexpected product: value %0d col %0d row %0d",
                       o_rsp.product_value, o_rsp.product_column, o_rsp.product_row);
                error_count++;
            end else begin
                exp_rsp = pending_products.pop_front();
                if (o_rsp.product_value !== exp_rsp.product_value) begin
                    $error("product_value: expected %0d, got %0d",
                           exp_rsp.product_value, o_rsp.product_value);
                    error_count++;
                end
                if (o_rsp.product_column !== exp_rsp.product_column) begin
                    $error("product_column: expected %0d, got %0d",
                           exp_rsp.product_column, o_rsp.product_column);
                    error_count++;
                end
                if (o_rsp.product_row !== exp_rsp.product_row) begin
                    $error("product_row: expected %0d, got %0d",
                           exp_rsp.product_row, o_rsp.product_row);
                    error_count++;
                end
                if (o_rsp.final_flag !== exp_rsp.final_flag) begin
                    $error("final_flag: expected %0d, got %0d",
                           exp_rsp.final_flag, o_rsp.final_flag);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        error_count    = 0;
        cycle_count    = 0;
        fill_count     = 0;
        idle_on        = 1'b1;
        sender_gap_pct = 25;
        quiet_left     = 0;
        stall_left     = 0;
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity_passthrough();
        test_saturation();
        test_random_matrices(4);
        test_back_to_back(2);

        // Drain outstanding products, then allow for trailing output
        i_req_valid <= 1'b0;
        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
